[hdl/tpce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Touch pen calibration package
// Shared types and constants for the touch pen calibration and event block.
// ----------------------------------------------------------------------------
package tpce_pkg;

  localparam int RAW_W   = 16;
  localparam int RES_W   = 12;
  localparam int COORD_W = 16;
  localparam int PROD_W  = RAW_W + RES_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int CNT_W     = 4;

  localparam logic [1:0] EV_DOWN = 2'd0;
  localparam logic [1:0] EV_MOVE = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_X_RES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd5;

  localparam logic [RES_W-1:0] RST_X_RES = 12'd640;
  localparam logic [RES_W-1:0] RST_Y_RES = 12'd240;
  localparam logic [RAW_W-1:0] RST_X_MIN = 16'd335;
  localparam logic [RAW_W-1:0] RST_X_MAX = 16'd3825;
  localparam logic [RAW_W-1:0] RST_Y_MIN = 16'd330;
  localparam logic [RAW_W-1:0] RST_Y_MAX = 16'd3490;

  typedef struct packed {
    logic [RAW_W-1:0] pen_word;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic [1:0]                event_kind;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic                      pressed;
  } result_t;

  typedef struct packed {
    logic [RES_W-1:0] x_resolution;
    logic [RES_W-1:0] y_resolution;
    logic [RAW_W-1:0] x_raw_min;
    logic [RAW_W-1:0] x_raw_max;
    logic [RAW_W-1:0] y_raw_min;
    logic [RAW_W-1:0] y_raw_max;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SAVE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic save;
    logic emit;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic pen;
    logic pen_down;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/tpce_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Calibration register file
// Holds the six calibration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tpce_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tpce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpce_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tpce_pkg::cfg_t                        cfg
);
  import tpce_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_resolution <= RST_X_RES;
      cfg.y_resolution <= RST_Y_RES;
      cfg.x_raw_min    <= RST_X_MIN;
      cfg.x_raw_max    <= RST_X_MAX;
      cfg.y_raw_min    <= RST_Y_MIN;
      cfg.y_raw_max    <= RST_Y_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_RES: cfg.x_resolution <= cfg_data[RES_W-1:0];
        REG_Y_RES: cfg.y_resolution <= cfg_data[RES_W-1:0];
        REG_X_MIN: cfg.x_raw_min    <= cfg_data[RAW_W-1:0];
        REG_X_MAX: cfg.x_raw_max    <= cfg_data[RAW_W-1:0];
        REG_Y_MIN: cfg.y_raw_min    <= cfg_data[RAW_W-1:0];
        REG_Y_MAX: cfg.y_raw_max    <= cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/tpce_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Calibration controller
// Sequences the multiply, divide and save steps for both axes, then the event, if the pen state calls for one.
// ----------------------------------------------------------------------------
module tpce_ctrl (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   sample_valid,
  output logic        sample_stall,
  input  wire tpce_pkg::sts_t sts,
  output tpce_pkg::cmd_t cmd
);
  import tpce_pkg::*;

  state_t           state;
  state_t           state_next;
  logic             axis;
  logic [CNT_W-1:0] count;
  logic             emit_needed;

  assign emit_needed = sts.pen || sts.pen_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        axis <= AXIS_X;
      end else if (state == ST_SAVE) begin
        axis <= AXIS_Y;
      end
      if (state == ST_MUL) begin
        count <= '0;
      end else if (state == ST_DIV) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (count == CNT_W'(DIV_STEPS - 1)) state_next = ST_SAVE;
      end
      ST_SAVE: begin
        state_next = (axis == AXIS_Y) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (!emit_needed || sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid;
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_SAVE: cmd.save     = 1'b1;
      ST_EMIT: cmd.emit     = emit_needed && sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hdl/tpce_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Calibration datapath
// Scales one axis at a time with a multiplier and a shared radix-4 divider,
// tracks the pen state and holds the result register.
// ----------------------------------------------------------------------------
module tpce_datapath (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tpce_pkg::sample_t sample,
  input  wire tpce_pkg::cfg_t    cfg,
  input  wire tpce_pkg::cmd_t    cmd,
  output tpce_pkg::sts_t    sts,
  output logic              result_valid,
  input  wire logic         result_stall,
  output tpce_pkg::result_t result
);
  import tpce_pkg::*;

  sample_t             smp;
  logic [PROD_W-1:0]   quo;
  logic [RAW_W-1:0]    rem;
  logic [RAW_W-1:0]    den;
  logic                neg;
  logic                empty;
  logic [COORD_W-1:0]  sx;
  logic [COORD_W-1:0]  sy;
  logic [COORD_W-1:0]  last_x;
  logic [COORD_W-1:0]  last_y;
  logic                pen_down;

  logic [RAW_W-1:0]    raw;
  logic [RAW_W-1:0]    lo;
  logic [RAW_W-1:0]    hi;
  logic [RES_W-1:0]    res;
  logic [RAW_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;

  logic [RAW_W:0]      t1;
  logic [RAW_W:0]      t2;
  logic                ge1;
  logic                ge2;
  logic [RAW_W-1:0]    r1;
  logic [RAW_W-1:0]    r2;
  logic [PROD_W-1:0]   q1;
  logic [PROD_W-1:0]   q2;

  logic [COORD_W-1:0]  sat;
  logic                pen;

  assign pen = |smp.pen_word;

  always_comb begin
    if (cmd.axis == AXIS_X) begin
      raw = smp.raw_x;
      lo  = cfg.x_raw_min;
      hi  = cfg.x_raw_max;
      res = cfg.x_resolution;
    end else begin
      raw = smp.raw_y;
      lo  = cfg.y_raw_min;
      hi  = cfg.y_raw_max;
      res = cfg.y_resolution;
    end
    mag  = (raw >= lo) ? raw - lo : lo - raw;
    prod = PROD_W'(mag) * PROD_W'(res);
  end

  always_comb begin
    t1  = {rem, quo[PROD_W-1]};
    ge1 = t1 >= {1'b0, den};
    r1  = ge1 ? RAW_W'(t1 - {1'b0, den}) : t1[RAW_W-1:0];
    q1  = {quo[PROD_W-2:0], ge1};
    t2  = {r1, q1[PROD_W-1]};
    ge2 = t2 >= {1'b0, den};
    r2  = ge2 ? RAW_W'(t2 - {1'b0, den}) : t2[RAW_W-1:0];
    q2  = {q1[PROD_W-2:0], ge2};
  end

  always_comb begin
    if (empty) begin
      sat = '0;
    end else if (!neg) begin
      sat = (|quo[PROD_W-1:COORD_W-1]) ? {1'b0, {(COORD_W-1){1'b1}}}
                                        : {1'b0, quo[COORD_W-2:0]};
    end else if (quo > PROD_W'(1 << (COORD_W - 1))) begin
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat = COORD_W'(-quo[COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) smp <= sample;
    if (cmd.mul) begin
      quo   <= prod;
      rem   <= '0;
      den   <= hi - lo;
      neg   <= raw < lo;
      empty <= hi <= lo;
    end else if (cmd.div_step) begin
      quo <= q2;
      rem <= r2;
    end
    if (cmd.save) begin
      if (cmd.axis == AXIS_X) begin
        sx <= sat;
      end else begin
        sy <= sat;
      end
    end
    if (cmd.emit) begin
      if (pen) begin
        result.event_kind <= pen_down ? EV_MOVE : EV_DOWN;
        result.screen_x   <= sx;
        result.screen_y   <= sy;
        result.pressed    <= 1'b1;
      end else begin
        result.event_kind <= EV_UP;
        result.screen_x   <= last_x;
        result.screen_y   <= last_y;
        result.pressed    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_down     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pen_down     <= pen;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (cmd.emit) begin
      last_x <= sx;
      last_y <= sy;
    end
  end

  assign sts.pen      = pen;
  assign sts.pen_down = pen_down;
  assign sts.out_free = !result_valid || !result_stall;

endmodule
`default_nettype wire

[hdl/touch_pen_calibrate_event_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Touch pen calibration and event block
// Scales raw touch samples to screen coordinates and turns the pen state into
// down, move and up events.
// ----------------------------------------------------------------------------
// A result is registered once both axes have passed the multiply, divide and
// save steps and the emit step; no new sample is taken until then. The shared
// divider retires two quotient bits a cycle and serves X and then Y.
// A stalled result can hold the emit step and so hold off the next sample.
// Reset restores the calibration defaults, clears the pen state and the saved
// coordinates, and empties the output register.
module touch_pen_calibrate_event_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire tpce_pkg::sample_t               sample,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output tpce_pkg::result_t                    result,
  input  wire logic                            cfg_we,
  input  wire logic [tpce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpce_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tpce_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpce_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  tpce_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

[bench/tpce_event_checker.sv]
// ----------------------------------------------------------------------------
// Touch pen event checker
// Watches the sample, result and configuration ports of the touch pen
// calibration block. It keeps its own copy of the calibration registers and
// the pen tracker, predicts the event for each sample transfer that needs one,
// and compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tpce_event_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  input  wire logic                            sample_stall,
  input  tpce_pkg::sample_t                    sample,
  input  wire logic                            result_valid,
  input  wire logic                            result_stall,
  input  tpce_pkg::result_t                    result,
  input  wire logic                            cfg_we,
  input  wire logic [tpce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpce_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  import tpce_pkg::*;

  result_t             predicted_events[$];
  logic [RES_W-1:0]    x_res;
  logic [RES_W-1:0]    y_res;
  logic [RAW_W-1:0]    x_min;
  logic [RAW_W-1:0]    x_max;
  logic [RAW_W-1:0]    y_min;
  logic [RAW_W-1:0]    y_max;
  logic                pen_down;
  logic [COORD_W-1:0]  saved_x;
  logic [COORD_W-1:0]  saved_y;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [COORD_W-1:0] calibrate_axis(input logic [RAW_W-1:0] raw,
                                                        input logic [RAW_W-1:0] lo,
                                                        input logic [RAW_W-1:0] hi,
                                                        input logic [RES_W-1:0] res);
    longint r;
    longint l;
    longint h;
    longint s;
    longint quot;
    if (hi <= lo) begin
      return '0;
    end
    r = longint'(raw);
    l = longint'(lo);
    h = longint'(hi);
    s = longint'(res);
    quot = ((r - l) * s) / (h - l);
    if (quot > 32767) begin
      quot = 32767;
    end
    if (quot < -32768) begin
      quot = -32768;
    end
    return quot[COORD_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 100) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    result_t            want;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    if (rst) begin
      predicted_events.delete();
      x_res    = RST_X_RES;
      y_res    = RST_Y_RES;
      x_min    = RST_X_MIN;
      x_max    = RST_X_MAX;
      y_min    = RST_Y_MIN;
      y_max    = RST_Y_MAX;
      pen_down = 1'b0;
      saved_x  = '0;
      saved_y  = '0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_events.size() == 0) begin
          report_mismatch($sformatf("result transfer %h with no event predicted", result));
        end else begin
          want = predicted_events.pop_front();
          if (result.event_kind !== want.event_kind) begin
            report_mismatch($sformatf("event_kind got %0d want %0d",
                                      result.event_kind, want.event_kind));
          end
          if (result.screen_x !== want.screen_x) begin
            report_mismatch($sformatf("screen_x got %0d want %0d",
                                      result.screen_x, want.screen_x));
          end
          if (result.screen_y !== want.screen_y) begin
            report_mismatch($sformatf("screen_y got %0d want %0d",
                                      result.screen_y, want.screen_y));
          end
          if (result.pressed !== want.pressed) begin
            report_mismatch($sformatf("pressed got %0d want %0d",
                                      result.pressed, want.pressed));
          end
        end
      end

      if (sample_valid && !sample_stall) begin
        sx = calibrate_axis(sample.raw_x, x_min, x_max, x_res);
        sy = calibrate_axis(sample.raw_y, y_min, y_max, y_res);
        if (sample.pen_word != '0) begin
          want.event_kind = pen_down ? EV_MOVE : EV_DOWN;
          want.screen_x   = sx;
          want.screen_y   = sy;
          want.pressed    = 1'b1;
          predicted_events.push_back(want);
          pen_down = 1'b1;
          saved_x  = sx;
          saved_y  = sy;
        end else if (pen_down) begin
          want.event_kind = EV_UP;
          want.screen_x   = saved_x;
          want.screen_y   = saved_y;
          want.pressed    = 1'b0;
          predicted_events.push_back(want);
          pen_down = 1'b0;
          saved_x  = sx;
          saved_y  = sy;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_X_RES: x_res = cfg_data[RES_W-1:0];
          REG_Y_RES: y_res = cfg_data[RES_W-1:0];
          REG_X_MIN: x_min = cfg_data[RAW_W-1:0];
          REG_X_MAX: x_max = cfg_data[RAW_W-1:0];
          REG_Y_MIN: y_min = cfg_data[RAW_W-1:0];
          REG_Y_MAX: y_max = cfg_data[RAW_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= predicted_events.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Touch pen calibration testbench
// Drives touch samples and calibration settings into the block under random
// idling and back-pressure, starting with directed edge cases and then pen
// strokes with random content, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
  import tpce_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 115;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int fail_count;
  int pending;

  bit calm        = 1'b0;
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  logic [RAW_W-1:0] cur_x_min = RST_X_MIN;
  logic [RAW_W-1:0] cur_x_max = RST_X_MAX;
  logic [RAW_W-1:0] cur_y_min = RST_Y_MIN;
  logic [RAW_W-1:0] cur_y_max = RST_Y_MAX;

  touch_pen_calibrate_event_top u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tpce_event_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // After 200 result transfers the receiver holds off long enough for the
  // block to fill up and stall its input.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left    <= hold_left - 1;
      end else if (results_seen >= 200 && !hold_done) begin
        result_stall <= 1'b1;
        hold_left    <= 300;
        hold_done    <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  task automatic send_sample(input logic [RAW_W-1:0] pen, input logic [RAW_W-1:0] rx,
                             input logic [RAW_W-1:0] ry);
    while (!calm && $urandom_range(99) < 19) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample.pen_word <= pen;
    sample.raw_x    <= rx;
    sample.raw_y    <= ry;
    sample_valid    <= 1'b1;
    @(posedge clk);
    while (sample_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_for_quiet();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_calibration(input logic [CFG_DATA_W-1:0] xr,
                                     input logic [CFG_DATA_W-1:0] yr,
                                     input logic [RAW_W-1:0] xlo, input logic [RAW_W-1:0] xhi,
                                     input logic [RAW_W-1:0] ylo, input logic [RAW_W-1:0] yhi);
    write_reg(REG_X_RES, xr);
    write_reg(REG_Y_RES, yr);
    write_reg(REG_X_MIN, xlo);
    write_reg(REG_X_MAX, xhi);
    write_reg(REG_Y_MIN, ylo);
    write_reg(REG_Y_MAX, yhi);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_x_min = xlo;
    cur_x_max = xhi;
    cur_y_min = ylo;
    cur_y_max = yhi;
  endtask

  task automatic pick_span(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
    int roll;
    roll = $urandom_range(9);
    case (roll)
      0: begin
        lo = RAW_W'($urandom);
        hi = lo;
      end
      1: begin
        hi = RAW_W'($urandom_range(60000));
        lo = hi + RAW_W'($urandom_range(5000, 1));
      end
      2: begin
        lo = 16'h0000;
        hi = 16'hFFFF;
      end
      3: begin
        lo = RAW_W'($urandom_range(65000));
        hi = lo + RAW_W'($urandom_range(15, 1));
      end
      default: begin
        lo = RAW_W'($urandom_range(8000));
        hi = lo + RAW_W'($urandom_range(50000, 100));
      end
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_res_word();
    int roll;
    logic [CFG_DATA_W-1:0] w;
    roll = $urandom_range(9);
    w = CFG_DATA_W'($urandom);
    case (roll)
      0: w[RES_W-1:0] = '0;
      1: w[RES_W-1:0] = '1;
      2: w[RES_W-1:0] = 12'd1;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] lo,
                                                input logic [RAW_W-1:0] hi);
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return 16'h0000;
    end
    if (roll == 1) begin
      return 16'hFFFF;
    end
    if (roll < 4 || hi <= lo) begin
      return RAW_W'($urandom);
    end
    return RAW_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [RAW_W-1:0] pick_press_word();
    logic [RAW_W-1:0] w;
    if ($urandom_range(3) == 0) begin
      return 16'h0001 << $urandom_range(15);
    end
    w = RAW_W'($urandom);
    if (w == '0) begin
      w = 16'h8000;
    end
    return w;
  endfunction

  // Strokes of presses, mostly closed by a release, sometimes left open so
  // that the next stroke continues as moves, sometimes with a stray release.
  task automatic run_strokes(input int count);
    int made;
    int presses;
    made = 0;
    while (made < count) begin
      presses = $urandom_range(8, 1);
      repeat (presses) begin
        send_sample(pick_press_word(), pick_raw(cur_x_min, cur_x_max),
                    pick_raw(cur_y_min, cur_y_max));
      end
      made += presses;
      if ($urandom_range(99) < 80) begin
        send_sample(16'h0000, pick_raw(cur_x_min, cur_x_max), pick_raw(cur_y_min, cur_y_max));
        made++;
        if ($urandom_range(99) < 15) begin
          send_sample(16'h0000, RAW_W'($urandom), RAW_W'($urandom));
        end
      end
    end
  endtask

  task automatic randomize_calibration();
    logic [RAW_W-1:0] xlo;
    logic [RAW_W-1:0] xhi;
    logic [RAW_W-1:0] ylo;
    logic [RAW_W-1:0] yhi;
    pick_span(xlo, xhi);
    pick_span(ylo, yhi);
    program_calibration(pick_res_word(), pick_res_word(), xlo, xhi, ylo, yhi);
  endtask

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(16'h0000, 16'd100, 16'd100);
    send_sample(16'h0001, 16'd335, 16'd330);
    send_sample(16'hFFFF, 16'd3825, 16'd3490);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0001, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'hFFFF, 16'hFFFF);
    send_sample(16'h5555, 16'd2080, 16'd1910);
    send_sample(16'hAAAA, 16'hAAAA, 16'h5555);
    send_sample(16'h0000, 16'h5555, 16'hAAAA);
    wait_for_quiet();

    program_calibration(16'hFFFF, 16'hF000, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF);
    send_sample(16'h0001, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 16'h0000, 16'h0000);
    send_sample(16'h0001, 16'h0001, 16'h0001);
    send_sample(16'h0000, 16'h1234, 16'h4321);
    wait_for_quiet();

    program_calibration(16'h0FFF, 16'h0001, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 16'h0000, 16'h0000);
    send_sample(16'h0002, 16'hFFFF, 16'h0000);
    send_sample(16'h0004, 16'hFFFE, 16'h0008);
    send_sample(16'h0000, 16'h0000, 16'hFFFF);
    wait_for_quiet();

    program_calibration(16'h0FFF, 16'h0FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'h8000, 16'h1234);
    send_sample(16'h0000, 16'h7FFF, 16'hEDCB);

    for (int phase = 0; phase < 10; phase++) begin
      wait_for_quiet();
      if (phase == 0) begin
        program_calibration(CFG_DATA_W'(RST_X_RES), CFG_DATA_W'(RST_Y_RES), RST_X_MIN,
                            RST_X_MAX, RST_Y_MIN, RST_Y_MAX);
      end else begin
        randomize_calibration();
      end
      calm <= (phase == 3);
      if (phase == 5) begin
        run_strokes(60);
        wait_for_quiet();
        run_strokes(PHASE_ITEMS - 60);
      end else begin
        run_strokes(PHASE_ITEMS);
      end
    end
    calm <= 1'b0;
    wait_for_quiet();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
